### rtl/core/bkdb_pkg.sv
// ----------------------------------------------------------------------------
// bkdb_pkg
// Shared constants and types for the bounded key dedup buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package bkdb_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int KEY_BITS_DEF = 48;

	localparam logic MODE_KEY   = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	typedef struct packed {
		logic shift;
		logic append;
	} bkdb_cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/core/bkdb_if.sv
// ----------------------------------------------------------------------------
// bkdb interfaces
// Valid/ready channels for key words in and flushed key words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bkdb_in_if #(
	parameter int KEY_BITS = 48
);
	logic                valid;
	logic                ready;
	logic                mode;
	logic [KEY_BITS-1:0] key_in;

	modport source (output valid, output mode, output key_in, input ready);
	modport sink   (input valid, input mode, input key_in, output ready);
endinterface

interface bkdb_out_if #(
	parameter int KEY_BITS = 48
);
	logic                valid;
	logic                ready;
	logic [KEY_BITS-1:0] key_out;
	logic                last;

	modport source (output valid, output key_out, output last, input ready);
	modport sink   (input valid, input key_out, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/bkdb_cell.sv
// ----------------------------------------------------------------------------
// bkdb_cell
// One table slot: holds a key, compares it with the incoming key, takes an
// appended key when it is the first free slot, shifts toward the output.
// ----------------------------------------------------------------------------
`default_nettype none

module bkdb_cell
	import bkdb_pkg::*;
#(
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bkdb_cell_ctrl_t     ctrl,
	input  wire logic [KEY_BITS-1:0] new_key,
	input  wire logic                prev_valid,
	input  wire logic [KEY_BITS-1:0] nbr_key,
	input  wire logic                nbr_valid,
	output logic [KEY_BITS-1:0]      key,
	output logic                     valid,
	output logic                     match
);

	logic [KEY_BITS-1:0] key_q;
	logic                valid_q;
	logic                take;

	assign take  = ctrl.append && prev_valid && !valid_q;
	assign match = valid_q && (key_q == new_key);
	assign key   = key_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= nbr_valid;
		end else if (take) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			key_q <= nbr_key;
		end else if (take) begin
			key_q <= new_key;
		end
	end

endmodule

`default_nettype wire

### rtl/core/bounded_key_dedup_buffer_unit.sv
// ----------------------------------------------------------------------------
// bounded_key_dedup_buffer_unit
// Duplicate filter over a key stream using a chain of table cells.
//
//   channel  dir  fields          word
//   din      in   mode, key_in    key or end-of-stream marker
//   dout     out  key_out, last   flushed key, last marks end of run
//
// A key word that is a duplicate or is appended needs no flush; din takes
// a word every cycle while no flush runs. A flush moves the cell chain one
// slot toward dout per taken word until the chain is empty, then closes
// (and stores the pending key); din is held off meanwhile.
// Reset clears all valid bits; dout stalls hold the chain in place.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_key_dedup_buffer_unit
	import bkdb_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bkdb_in_if.sink    din,
	bkdb_out_if.source dout
);

	logic [KEY_BITS-1:0] cell_key   [CAPACITY+1];
	logic                cell_valid [CAPACITY+1];
	logic [CAPACITY-1:0] cell_match;

	bkdb_cell_ctrl_t     ctrl;
	logic [KEY_BITS-1:0] new_key;
	logic                flushing_q;
	logic                pending_q;
	logic [KEY_BITS-1:0] pend_key_q;
	logic                out_valid_q;
	logic [KEY_BITS-1:0] out_key_q;
	logic                out_last_q;

	logic accept;
	logic hit;
	logic full;
	logic out_free;
	logic step;

	assign cell_key[CAPACITY]   = '0;
	assign cell_valid[CAPACITY] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		bkdb_cell #(.KEY_BITS(KEY_BITS)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_key    (new_key),
			.prev_valid ((i == 0) ? 1'b1 : cell_valid[(i == 0) ? 0 : i-1]),
			.nbr_key    (cell_key[i+1]),
			.nbr_valid  (cell_valid[i+1]),
			.key        (cell_key[i]),
			.valid      (cell_valid[i]),
			.match      (cell_match[i])
		);
	end

	assign din.ready = !flushing_q;
	assign accept    = din.valid && !flushing_q;
	assign hit       = |cell_match;
	assign full      = cell_valid[CAPACITY-1];
	assign out_free  = !out_valid_q || dout.ready;
	assign step      = flushing_q && cell_valid[0] && out_free;
	assign new_key   = flushing_q ? pend_key_q : din.key_in;

	always_comb begin
		ctrl.shift  = step;
		ctrl.append = 1'b0;
		if (flushing_q) begin
			ctrl.append = !cell_valid[0] && pending_q;
		end else if (accept && din.mode == MODE_KEY) begin
			ctrl.append = !hit && !full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flushing_q  <= 1'b0;
			pending_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (flushing_q) begin
				if (!cell_valid[0]) begin
					flushing_q <= 1'b0;
					pending_q  <= 1'b0;
				end
			end else if (accept) begin
				unique case (din.mode)
					MODE_FLUSH: begin
						if (cell_valid[0]) begin
							flushing_q <= 1'b1;
							pending_q  <= 1'b0;
						end
					end
					MODE_KEY: begin
						if (!hit && full) begin
							flushing_q <= 1'b1;
							pending_q  <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!flushing_q && accept && din.mode == MODE_KEY) begin
			pend_key_q <= din.key_in;
		end
		if (step) begin
			out_key_q  <= cell_key[0];
			out_last_q <= !cell_valid[1];
		end
	end

	assign dout.valid   = out_valid_q;
	assign dout.key_out = out_key_q;
	assign dout.last    = out_last_q;

endmodule

`default_nettype wire

### rtl/core/bkdb_checker.sv
// ----------------------------------------------------------------------------
// bkdb_checker
// Port-level checks on the dedup buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bkdb_checker #(
	parameter int KEY_BITS = 48
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [KEY_BITS-1:0] out_key,
	input wire logic                out_last
);

	// stalled word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_last))
		else $error("stalled output word changed");

	// a word only shows up while a flush holds off input
	a_rise_in_flush: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("output word appeared outside a flush");

	// mid-run word means the flush is still going
	a_mid_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input taken in the middle of a flush run");

	// a taken non-last word is followed by another word
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_last |=> out_valid)
		else $error("flush run broke off before last");

endmodule

bind bounded_key_dedup_buffer_unit bkdb_checker #(.KEY_BITS(KEY_BITS)) u_bkdb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.out_key   (dout.key_out),
	.out_last  (dout.last)
);

`default_nettype wire
